[rtl/streaming_set_cover_engine_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the streaming set cover engine
// Shared concurrent assertion forms. Each use expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef STREAMING_SET_COVER_ENGINE_DEFINES_SVH
`define STREAMING_SET_COVER_ENGINE_DEFINES_SVH

// The condition holds at every rising clock edge outside reset.
`define SCE_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define SCE_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[rtl/sce_pkg.sv]
// ----------------------------------------------------------------------------
// Set cover engine package
// Field widths, codes and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sce_pkg;

	localparam int ELEM_W     = 10;
	localparam int SET_W      = 16;
	localparam int BASE_W     = 5;
	localparam int EFF_W      = 4;
	localparam int SIZE_W     = 7;
	localparam int LVL_W      = 3;
	localparam int HIST_DEPTH = 8;
	localparam int TBL_W      = EFF_W + 1 + SET_W;

	localparam logic [LVL_W-1:0]        LEVEL_MAX  = 3'd7;
	localparam logic [BASE_W-1:0]       BASE_RESET = 5'd2;
	localparam logic [BASE_W-1:0]       BASE_MIN   = 5'd2;
	localparam logic signed [EFF_W-1:0] EFF_NONE   = -4'sd1;

	localparam logic OP_OFFER     = 1'b0;
	localparam logic OP_QUERY     = 1'b1;
	localparam logic KIND_REPORT  = 1'b0;
	localparam logic KIND_QUERY   = 1'b1;

	// Table word after reset: effectivity -1, unassigned, owner 0.
	localparam logic [TBL_W-1:0] TBL_INIT = {EFF_NONE, 1'b0, {SET_W{1'b0}}};

	typedef struct packed {
		logic clr_step;
		logic offer;
		logic query;
		logic cap_start;
		logic cap_take;
		logic snap_step;
		logic scan_start;
		logic scan_take;
		logic lvl_start;
		logic lvl_take;
		logic write_step;
		logic report_load;
		logic query_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic lu_done;
		logic snap_done;
		logic scan_done;
		logic chosen_zero;
		logic write_done;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

[rtl/sce_if.sv]
// ----------------------------------------------------------------------------
// Set cover engine channels
// Valid/ready channels for input words, result words and the base register.
// ----------------------------------------------------------------------------
`default_nettype none

interface sce_in_if;
	import sce_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 op;
	logic [ELEM_W-1:0]    element;
	logic [SET_W-1:0]     set_index;
	logic                 last;
	modport source (output valid, op, element, set_index, last, input ready);
	modport sink   (input valid, op, element, set_index, last, output ready);
endinterface

interface sce_out_if;
	import sce_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic [SIZE_W-1:0]        subset_size;
	logic signed [EFF_W-1:0]  level;
	logic [SET_W-1:0]         owner_set;
	logic                     assigned;
	modport source (output valid, kind, subset_size, level, owner_set, assigned, input ready);
	modport sink   (input valid, kind, subset_size, level, owner_set, assigned, output ready);
endinterface

interface sce_cfg_if;
	import sce_pkg::*;
	logic              valid;
	logic              ready;
	logic [BASE_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[rtl/sce_level_unit.sv]
// ----------------------------------------------------------------------------
// Level unit
// Finds the smallest k with base^k >= n, saturated at seven, one multiply
// per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sce_level_unit #(
	parameter int CNT_W = 7
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [CNT_W-1:0]               n,
	input  logic [sce_pkg::BASE_W-1:0]     base,
	output logic                           done,
	output logic [sce_pkg::LVL_W-1:0]      k
);
	import sce_pkg::*;

	localparam int PW = CNT_W + BASE_W;

	logic              busy_q;
	logic [PW-1:0]     p_q;
	logic [CNT_W-1:0]  n_q;
	logic [LVL_W-1:0]  k_q;
	logic [BASE_W-1:0] b_eff;
	logic              more;

	// A base below two behaves as two.
	assign b_eff = (base < BASE_MIN) ? BASE_MIN : base;
	assign more  = (p_q < PW'(n_q)) && (k_q != LEVEL_MAX);
	assign done  = busy_q && !more;
	assign k     = k_q;

	// Control: busy while the power is below the count and the exponent below seven.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// Power and exponent registers.
	always_ff @(posedge clk) begin
		if (start) begin
			p_q <= PW'(1);
			k_q <= '0;
			n_q <= n;
		end else if (busy_q && more) begin
			p_q <= PW'(p_q * b_eff);
			k_q <= k_q + LVL_W'(1);
		end
	end

endmodule

`default_nettype wire

[rtl/sce_datapath.sv]
// ----------------------------------------------------------------------------
// Set cover datapath
// Element table, set buffer, snapshot memory, histogram, scan registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "streaming_set_cover_engine_defines.svh"

module sce_datapath #(
	parameter int UNIVERSE_SIZE = 1024,
	parameter int MAX_SET_SIZE  = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sce_pkg::cmd_t                     cmd,
	output sce_pkg::stat_t                    stat,
	input  logic [sce_pkg::ELEM_W-1:0]        in_element,
	input  logic [sce_pkg::SET_W-1:0]         in_set_index,
	input  logic                              cfg_we,
	input  logic [sce_pkg::BASE_W-1:0]        cfg_data,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic                              out_kind,
	output logic [sce_pkg::SIZE_W-1:0]        out_subset_size,
	output logic signed [sce_pkg::EFF_W-1:0]  out_level,
	output logic [sce_pkg::SET_W-1:0]         out_owner_set,
	output logic                              out_assigned
);
	import sce_pkg::*;

	localparam int UW = $clog2(UNIVERSE_SIZE);
	localparam int BW = $clog2(MAX_SET_SIZE);
	localparam int CW = $clog2(MAX_SET_SIZE + 1);

	// Memories.
	logic [TBL_W-1:0]        tbl_mem [UNIVERSE_SIZE];
	logic [UW-1:0]           buf_mem [MAX_SET_SIZE];
	logic signed [EFF_W-1:0] snap_mem [MAX_SET_SIZE];

	logic [BASE_W-1:0]       base_q;
	logic [CW-1:0]           cnt_q;
	logic [CW-1:0]           idx_q;
	logic [UW-1:0]           clr_q;
	logic                    v_s1, v_s2;
	logic [BW-1:0]           idx_s1, idx_s2;
	logic [CW-1:0]           hist_q [HIST_DEPTH];
	logic [LVL_W-1:0]        cap_q;
	logic [CW-1:0]           run_q;
	logic [CW-1:0]           chosen_q;
	logic signed [EFF_W-1:0] crit_q;
	logic signed [EFF_W-1:0] lvl_q;
	logic [3:0]              scan_q;
	logic [SET_W-1:0]        set_q;
	logic                    q_in_q;
	logic [TBL_W-1:0]        tbl_rd_q;
	logic [UW-1:0]           buf_rd_q;
	logic signed [EFF_W-1:0] snap_rd_q;
	logic                    out_valid_q;

	logic                    in_univ;
	logic [UW-1:0]           elem_idx;
	logic                    issue;
	logic                    tbl_re;
	logic [UW-1:0]           tbl_ra;
	logic                    tbl_we;
	logic [UW-1:0]           tbl_wa;
	logic [TBL_W-1:0]        tbl_wd;
	logic                    wr_hit;
	logic signed [EFF_W-1:0] rd_eff;
	logic                    hist_hit;
	logic [2:0]              hist_idx;
	logic [CW-1:0]           run_next;
	logic                    lu_start;
	logic [CW-1:0]           lu_n;
	logic                    lu_done;
	logic [LVL_W-1:0]        lu_k;
	logic                    out_load;

	assign in_univ  = 32'(in_element) < UNIVERSE_SIZE;
	assign elem_idx = UW'(in_element);
	assign issue    = (cmd.snap_step || cmd.write_step) && (idx_q < cnt_q);
	assign rd_eff   = tbl_rd_q[TBL_W-1 -: EFF_W];
	assign run_next = run_q + hist_q[scan_q[2:0]];
	assign out_load = cmd.report_load || cmd.query_load;

	// Histogram bin of a snapshot effectivity that lies below the capacity.
	assign hist_hit = v_s2 && (rd_eff >= EFF_NONE) && (rd_eff < 4'sd7)
		&& (rd_eff < $signed({1'b0, cap_q}));
	assign hist_idx = 3'(rd_eff + 4'sd1);

	// Table port selection.
	assign wr_hit = cmd.write_step && v_s1 && (snap_rd_q <= crit_q);
	assign tbl_re = cmd.query || (cmd.snap_step && v_s1);
	assign tbl_ra = cmd.query ? elem_idx : buf_rd_q;
	assign tbl_we = cmd.clr_step || wr_hit;
	assign tbl_wa = cmd.clr_step ? clr_q : buf_rd_q;
	assign tbl_wd = cmd.clr_step ? TBL_INIT : {lvl_q, 1'b1, set_q};

	// Shared level unit.
	assign lu_start = cmd.cap_start || cmd.scan_start || cmd.lvl_start;
	always_comb begin
		priority if (cmd.cap_start) begin
			lu_n = cnt_q;
		end else if (cmd.scan_start) begin
			lu_n = run_next;
		end else begin
			lu_n = chosen_q;
		end
	end

	sce_level_unit #(.CNT_W(CW)) u_level (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lu_start),
		.n      (lu_n),
		.base   (base_q),
		.done   (lu_done),
		.k      (lu_k)
	);

	// Status back to the controller.
	assign stat.clr_last    = clr_q == UW'(UNIVERSE_SIZE - 1);
	assign stat.lu_done     = lu_done;
	assign stat.snap_done   = (idx_q == cnt_q) && !v_s1 && !v_s2;
	assign stat.write_done  = (idx_q == cnt_q) && !v_s1;
	assign stat.scan_done   = scan_q > {1'b0, cap_q};
	assign stat.chosen_zero = chosen_q == '0;
	assign stat.out_free    = !out_valid_q || out_ready;

	// Element table memory.
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_wa] <= tbl_wd;
		end
		if (tbl_re) begin
			tbl_rd_q <= tbl_mem[tbl_ra];
		end
	end

	// Set buffer and snapshot memories.
	always_ff @(posedge clk) begin
		if (cmd.offer && in_univ && (cnt_q < CW'(MAX_SET_SIZE))) begin
			buf_mem[cnt_q[BW-1:0]] <= elem_idx;
		end
		if (v_s2) begin
			snap_mem[idx_s2] <= rd_eff;
		end
		if (issue) begin
			buf_rd_q  <= buf_mem[idx_q[BW-1:0]];
			snap_rd_q <= snap_mem[idx_q[BW-1:0]];
		end
	end

	// Control registers: counters, walk pipeline, histogram, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= BASE_RESET;
			cnt_q       <= '0;
			idx_q       <= '0;
			clr_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < HIST_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				base_q <= cfg_data;
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + UW'(1);
			end
			if (cmd.report_load) begin
				cnt_q <= '0;
			end else if (cmd.offer && in_univ && (cnt_q < CW'(MAX_SET_SIZE))) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.cap_start || cmd.lvl_take) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
			v_s1 <= issue;
			v_s2 <= v_s1 && cmd.snap_step;
			if (cmd.cap_start) begin
				scan_q <= '0;
				for (int i = 0; i < HIST_DEPTH; i++) begin
					hist_q[i] <= '0;
				end
			end else begin
				if (hist_hit) begin
					hist_q[hist_idx] <= hist_q[hist_idx] + CW'(1);
				end
				if (cmd.scan_take) begin
					scan_q <= scan_q + 4'd1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers of the set walk and scan.
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[BW-1:0];
		idx_s2 <= idx_s1;
		if (cmd.offer) begin
			set_q <= in_set_index;
		end
		if (cmd.query) begin
			q_in_q <= in_univ;
		end
		if (cmd.cap_start) begin
			run_q    <= '0;
			chosen_q <= '0;
			crit_q   <= EFF_NONE;
			lvl_q    <= EFF_NONE;
		end
		if (cmd.cap_take) begin
			cap_q <= lu_k;
		end
		if (cmd.scan_start) begin
			run_q <= run_next;
		end
		// Effectivity scan-1 is critical when the running count levels above it.
		if (cmd.scan_take && (run_q != '0) && ({1'b0, lu_k} >= scan_q)) begin
			crit_q   <= $signed(scan_q - 4'd1);
			chosen_q <= run_q;
		end
		if (cmd.lvl_take) begin
			lvl_q <= $signed({1'b0, lu_k});
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.report_load) begin
			out_kind        <= KIND_REPORT;
			out_subset_size <= SIZE_W'(chosen_q);
			out_level       <= lvl_q;
			out_owner_set   <= '0;
			out_assigned    <= 1'b0;
		end else if (cmd.query_load) begin
			out_kind        <= KIND_QUERY;
			out_subset_size <= '0;
			out_level       <= q_in_q ? rd_eff : EFF_NONE;
			out_owner_set   <= q_in_q ? tbl_rd_q[SET_W-1:0] : '0;
			out_assigned    <= q_in_q ? tbl_rd_q[SET_W] : 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`SCE_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CW'(MAX_SET_SIZE), "buffer count above capacity")
	`SCE_ASSERT_IMPLY(a_load_free, out_load, !out_valid_q || out_ready, "result overwritten")
	`SCE_ASSERT_IMPLY(a_write_chosen, wr_hit, chosen_q != '0, "table write with empty subset")

endmodule

`default_nettype wire

[rtl/sce_ctrl.sv]
// ----------------------------------------------------------------------------
// Set cover controller
// Sequences clearing, buffering, queries, snapshot, scan, level, write-back and report.
// ----------------------------------------------------------------------------
`default_nettype none

module sce_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_op,
	input  logic            in_last,
	output logic            in_ready,
	output sce_pkg::cmd_t   cmd,
	input  sce_pkg::stat_t  stat
);
	import sce_pkg::*;

	typedef enum logic [11:0] {
		ST_CLEAR      = 12'b0000_0000_0001,
		ST_IDLE       = 12'b0000_0000_0010,
		ST_QUERY      = 12'b0000_0000_0100,
		ST_CAP        = 12'b0000_0000_1000,
		ST_CAP_WAIT   = 12'b0000_0001_0000,
		ST_SNAP       = 12'b0000_0010_0000,
		ST_SCAN       = 12'b0000_0100_0000,
		ST_SCAN_WAIT  = 12'b0000_1000_0000,
		ST_LEVEL      = 12'b0001_0000_0000,
		ST_LEVEL_WAIT = 12'b0010_0000_0000,
		ST_WRITE      = 12'b0100_0000_0000,
		ST_REPORT     = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign in_ready = state_q == ST_IDLE;
	assign accept   = in_valid && in_ready;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (in_op == OP_QUERY) begin
						cmd.query = 1'b1;
						state_d   = ST_QUERY;
					end else begin
						cmd.offer = 1'b1;
						if (in_last) state_d = ST_CAP;
					end
				end
			end
			ST_QUERY: begin
				if (stat.out_free) begin
					cmd.query_load = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_CAP: begin
				cmd.cap_start = 1'b1;
				state_d       = ST_CAP_WAIT;
			end
			ST_CAP_WAIT: begin
				if (stat.lu_done) begin
					cmd.cap_take = 1'b1;
					state_d      = ST_SNAP;
				end
			end
			ST_SNAP: begin
				cmd.snap_step = 1'b1;
				if (stat.snap_done) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.scan_done) begin
					state_d = ST_LEVEL;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN_WAIT;
				end
			end
			ST_SCAN_WAIT: begin
				if (stat.lu_done) begin
					cmd.scan_take = 1'b1;
					state_d       = ST_SCAN;
				end
			end
			ST_LEVEL: begin
				if (stat.chosen_zero) begin
					state_d = ST_REPORT;
				end else begin
					cmd.lvl_start = 1'b1;
					state_d       = ST_LEVEL_WAIT;
				end
			end
			ST_LEVEL_WAIT: begin
				if (stat.lu_done) begin
					cmd.lvl_take = 1'b1;
					state_d      = ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.write_step = 1'b1;
				if (stat.write_done) state_d = ST_REPORT;
			end
			ST_REPORT: begin
				if (stat.out_free) begin
					cmd.report_load = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[rtl/streaming_set_cover_engine.sv]
// ----------------------------------------------------------------------------
// Streaming set cover engine
// Buffers offered sets and reassigns elements to them by effectivity level.
// ----------------------------------------------------------------------------
// Usage: words enter on in_ch. An offer word (op 0) buffers its element when
// it lies in the universe and the buffer has room; the offer word with last
// set ends the set and produces one report word on out_ch. A query word (op 1)
// produces one answer word with the element's owner set and effectivity,
// loaded into the output register from ST_QUERY once that register is free.
// Processing a set after the acceptance of its last word runs a capacity level
// evaluation, a snapshot walk over the buffered elements, one level evaluation
// for each histogram bin up to the capacity, one for the chosen count and a
// write-back walk before the report load. When nothing is chosen, the
// write-back walk and the last evaluation are skipped. All of this runs through
// the single iterative level unit and the one port pair of the element table,
// so one item is handled at a time.
// cfg_ch writes the base register; it is to be written only while the engine is
// idle, which the engine itself does not enforce; it is always ready.
// After reset the engine sweeps the element table, one entry per cycle, over
// all UNIVERSE_SIZE entries, and holds in_ch.ready low until done.
// Results sit in an output register; while the receiver stalls, the engine
// still accepts words while idle, processes a completed set up to its report,
// and waits before loading the next result.
// ----------------------------------------------------------------------------
`default_nettype none

module streaming_set_cover_engine #(
	parameter int UNIVERSE_SIZE = 1024,
	parameter int MAX_SET_SIZE  = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	sce_in_if.sink     in_ch,
	sce_out_if.source  out_ch,
	sce_cfg_if.sink    cfg_ch
);
	import sce_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ch.ready = 1'b1;

	// Sequencer.
	sce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_op    (in_ch.op),
		.in_last  (in_ch.last),
		.in_ready (in_ch.ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	// Storage and arithmetic.
	sce_datapath #(
		.UNIVERSE_SIZE (UNIVERSE_SIZE),
		.MAX_SET_SIZE  (MAX_SET_SIZE)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.in_element      (in_ch.element),
		.in_set_index    (in_ch.set_index),
		.cfg_we          (cfg_ch.valid),
		.cfg_data        (cfg_ch.data),
		.out_ready       (out_ch.ready),
		.out_valid       (out_ch.valid),
		.out_kind        (out_ch.kind),
		.out_subset_size (out_ch.subset_size),
		.out_level       (out_ch.level),
		.out_owner_set   (out_ch.owner_set),
		.out_assigned    (out_ch.assigned)
	);

endmodule

`default_nettype wire
